FILE: rtl/tqs_pkg.sv
package tqs_pkg;

  localparam int FUNC_W = 2;
  localparam int ID_W   = 4;
  localparam int PRI_W  = 8;
  localparam int ST_W   = 2;

  // number of task ids that the request field can address
  localparam int ID_SPACE = 2 ** ID_W;

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

  localparam logic [ST_W-1:0] ST_FREE   = 2'd0;
  localparam logic [ST_W-1:0] ST_RUN    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTRUN = 2'd2;

  typedef logic [PRI_W-1:0] slice_t;

endpackage

FILE: rtl/tqs_if.sv
interface tqs_in_if;
  logic                        valid;
  logic                        ready;
  logic [tqs_pkg::FUNC_W-1:0]  func;
  logic [tqs_pkg::ID_W-1:0]    task_id;
  logic [tqs_pkg::PRI_W-1:0]   priority_req;
  logic [tqs_pkg::ST_W-1:0]    new_status;

  modport source (output valid, func, task_id, priority_req, new_status, input ready);
  modport sink   (input valid, func, task_id, priority_req, new_status, output ready);
  modport mon    (input valid, ready, func, task_id, priority_req, new_status);
endinterface

interface tqs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        run_valid;
  logic [tqs_pkg::ID_W-1:0]    run_task;
  tqs_pkg::slice_t             slices_remaining;
  logic                        idle;

  modport source (output valid, run_valid, run_task, slices_remaining, idle, input ready);
  modport sink   (input valid, run_valid, run_task, slices_remaining, idle, output ready);
  modport mon    (input valid, ready, run_valid, run_task, slices_remaining, idle);
endinterface

FILE: rtl/two_queue_time_slice_scheduler.sv
// channel    dir  payload                                          handshake
// in_chan    in   func, task_id, priority_req, new_status          valid / ready
// out_chan   out  run_valid, run_task, slices_remaining, idle      valid / ready
//
// add and status requests pass idle and done; a tick keeping the current task adds check
// a scanning tick adds scan and eval per entry examined, and a final scan if none runs;
// the scan loop pops one entry per pass through the shared queue memory port
// rst_n is synchronous: both queues empty, all tasks free, no task current
// in_chan.ready is high only between requests; a finished result waits in the output
// register, and a new request is taken while that result is still stalled

module two_queue_time_slice_scheduler #(
  parameter int NUM_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tqs_in_if.sink    in_chan,
  tqs_out_if.source out_chan
);

  localparam int TASK_SLOTS = (NUM_TASKS < tqs_pkg::ID_SPACE) ? NUM_TASKS : tqs_pkg::ID_SPACE;
  localparam int TIW        = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LW         = $clog2(TASK_SLOTS + 1);
  localparam int RING       = 2 ** TIW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [TIW-1:0]              cur_task_r, cur_task_nxt;
  logic                        cur_valid_r, cur_valid_nxt;
  tqs_pkg::slice_t             slice_r, slice_nxt;
  logic                        aq_r, aq_nxt;
  logic [TIW-1:0]              head_r [2];
  logic [TIW-1:0]              head_nxt [2];
  logic [TIW-1:0]              tail_r [2];
  logic [TIW-1:0]              tail_nxt [2];
  logic [LW-1:0]               len_r [2];
  logic [LW-1:0]               len_nxt [2];
  logic [LW-1:0]               budget_r, budget_nxt;
  logic [tqs_pkg::ST_W-1:0]    status_r [TASK_SLOTS];
  logic [tqs_pkg::ST_W-1:0]    status_nxt [TASK_SLOTS];
  tqs_pkg::slice_t             prio_r [TASK_SLOTS];
  tqs_pkg::slice_t             prio_nxt [TASK_SLOTS];
  logic                        queued_r [TASK_SLOTS];
  logic                        queued_nxt [TASK_SLOTS];
  logic                        res_tick_r, res_tick_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_run_valid_r, out_run_valid_nxt;
  logic [tqs_pkg::ID_W-1:0]    out_run_task_r, out_run_task_nxt;
  tqs_pkg::slice_t             out_slices_r, out_slices_nxt;
  logic                        out_idle_r, out_idle_nxt;

  // both queues share one ring memory, queue select in the top address bit
  logic [TIW-1:0]              queue_mem [2*RING];
  logic [TIW-1:0]              mem_rd_r;
  logic                        mem_we, mem_re;
  logic [TIW:0]                mem_waddr, mem_raddr;
  logic [TIW-1:0]              mem_wdata;

  logic                        in_ready, in_acc, id_ok, aq_eff, out_free;
  logic [TIW-1:0]              id_idx, st_idx;
  logic [tqs_pkg::ST_W-1:0]    st_rd;
  tqs_pkg::slice_t             pr_rd;

  assign in_ready        = (state_r == S_IDLE);
  assign in_chan.ready   = in_ready;
  assign in_acc          = in_chan.valid && in_ready;
  assign id_ok           = (32'(in_chan.task_id) < NUM_TASKS);
  assign id_idx          = TIW'(in_chan.task_id);
  assign st_idx          = (state_r == S_CHECK) ? cur_task_r : mem_rd_r;
  assign st_rd           = status_r[st_idx];
  assign pr_rd           = prio_r[mem_rd_r];
  // swap queues when the active one has run dry
  assign aq_eff          = (len_r[aq_r] == '0) ? ~aq_r : aq_r;
  assign out_free        = !out_valid_r || out_chan.ready;

  assign out_chan.valid            = out_valid_r;
  assign out_chan.run_valid        = out_run_valid_r;
  assign out_chan.run_task         = out_run_task_r;
  assign out_chan.slices_remaining = out_slices_r;
  assign out_chan.idle             = out_idle_r;

  always_comb begin
    state_nxt         = state_r;
    cur_task_nxt      = cur_task_r;
    cur_valid_nxt     = cur_valid_r;
    slice_nxt         = slice_r;
    aq_nxt            = aq_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    len_nxt           = len_r;
    budget_nxt        = budget_r;
    status_nxt        = status_r;
    prio_nxt          = prio_r;
    queued_nxt        = queued_r;
    res_tick_nxt      = res_tick_r;
    out_valid_nxt     = out_valid_r && !out_chan.ready;
    out_run_valid_nxt = out_run_valid_r;
    out_run_task_nxt  = out_run_task_r;
    out_slices_nxt    = out_slices_r;
    out_idle_nxt      = out_idle_r;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_waddr         = '0;
    mem_raddr         = '0;
    mem_wdata         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_tick_nxt = (in_chan.func == tqs_pkg::FUNC_TICK);
          priority if (in_chan.func == tqs_pkg::FUNC_TICK) begin
            state_nxt = S_CHECK;
          end else if (in_chan.func == tqs_pkg::FUNC_ADD) begin
            state_nxt = S_DONE;
            if (id_ok) begin
              prio_nxt[id_idx] = in_chan.priority_req;
              if (!queued_r[id_idx]) begin
                queued_nxt[id_idx] = 1'b1;
                if (32'(len_r[0]) < TASK_SLOTS) begin
                  mem_we      = 1'b1;
                  mem_waddr   = {1'b0, tail_r[0]};
                  mem_wdata   = id_idx;
                  tail_nxt[0] = tail_r[0] + 1'b1;
                  len_nxt[0]  = len_r[0] + 1'b1;
                end
              end
            end
          end else if (in_chan.func == tqs_pkg::FUNC_STATUS) begin
            state_nxt = S_DONE;
            if (id_ok && in_chan.new_status <= tqs_pkg::ST_NOTRUN) begin
              status_nxt[id_idx] = in_chan.new_status;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CHECK: begin
        if (cur_valid_r && slice_r != '0 && st_rd == tqs_pkg::ST_RUN) begin
          slice_nxt = slice_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          cur_valid_nxt = 1'b0;
          cur_task_nxt  = '0;
          slice_nxt     = '0;
          budget_nxt    = LW'(len_r[0] + len_r[1]);
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (budget_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          budget_nxt       = budget_r - 1'b1;
          aq_nxt           = aq_eff;
          mem_re           = 1'b1;
          mem_raddr        = {aq_eff, head_r[aq_eff]};
          head_nxt[aq_eff] = head_r[aq_eff] + 1'b1;
          len_nxt[aq_eff]  = len_r[aq_eff] - 1'b1;
          state_nxt        = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_SCAN;
        if (st_rd == tqs_pkg::ST_FREE) begin
          queued_nxt[mem_rd_r] = 1'b0;
        end else begin
          if (32'(len_r[~aq_r]) < TASK_SLOTS) begin
            mem_we         = 1'b1;
            mem_waddr      = {~aq_r, tail_r[~aq_r]};
            mem_wdata      = mem_rd_r;
            tail_nxt[~aq_r] = tail_r[~aq_r] + 1'b1;
            len_nxt[~aq_r]  = len_r[~aq_r] + 1'b1;
          end
          if (st_rd == tqs_pkg::ST_RUN) begin
            cur_task_nxt  = mem_rd_r;
            cur_valid_nxt = 1'b1;
            // zero priority still gets one slice, used by this tick
            slice_nxt     = (pr_rd == '0) ? '0 : pr_rd - 1'b1;
            state_nxt     = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_run_valid_nxt = res_tick_r && cur_valid_r;
          out_run_task_nxt  = (res_tick_r && cur_valid_r) ? tqs_pkg::ID_W'(cur_task_r) : '0;
          out_slices_nxt    = (res_tick_r && cur_valid_r) ? slice_r : '0;
          out_idle_nxt      = res_tick_r && !cur_valid_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_task_r  <= '0;
      cur_valid_r <= 1'b0;
      slice_r     <= '0;
      aq_r        <= 1'b0;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      len_r       <= '{default: '0};
      status_r    <= '{default: tqs_pkg::ST_FREE};
      queued_r    <= '{default: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_task_r  <= cur_task_nxt;
      cur_valid_r <= cur_valid_nxt;
      slice_r     <= slice_nxt;
      aq_r        <= aq_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      status_r    <= status_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    budget_r        <= budget_nxt;
    res_tick_r      <= res_tick_nxt;
    prio_r          <= prio_nxt;
    out_run_valid_r <= out_run_valid_nxt;
    out_run_task_r  <= out_run_task_nxt;
    out_slices_r    <= out_slices_nxt;
    out_idle_r      <= out_idle_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_r <= queue_mem[mem_raddr];
    end
  end

endmodule

FILE: rtl/tqs_checker.sv
module tqs_checker (
  input logic       clk,
  input logic       rst_n,
  tqs_in_if.sink    in_chan,
  tqs_out_if.source out_chan
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid)
    else $error("result dropped while stalled");

  a_run_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.run_valid && out_chan.idle))
    else $error("result shows both a running task and idle");

  a_no_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.run_valid |->
      out_chan.run_task == '0 && out_chan.slices_remaining == '0)
    else $error("task fields set without a running task");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request taken while the previous one is in work");

endmodule

bind two_queue_time_slice_scheduler tqs_checker u_tqs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
